>>> rtl/video_register_port_top_macros.svh
`ifndef VIDEO_REGISTER_PORT_TOP_MACROS_SVH
`define VIDEO_REGISTER_PORT_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define VRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define VRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/vrp_pkg.sv
`default_nettype none

package vrp_pkg;

  localparam int NT_BYTES      = 2048;
  localparam int PATTERN_BYTES = 8192;
  localparam int OAM_BYTES     = 256;
  localparam int PAL_BYTES     = 32;
  localparam int NT_AW         = $clog2(NT_BYTES);
  localparam int PAT_AW        = $clog2(PATTERN_BYTES);
  localparam int OAM_AW        = $clog2(OAM_BYTES);
  localparam int PAL_AW        = $clog2(PAL_BYTES);

  // result queue
  localparam int QDEPTH = 3;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_SET   = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [1:0] MIR_VERT = 2'd0;
  localparam logic [1:0] MIR_HORZ = 2'd1;

  // where the byte pending in the read pipeline comes from
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_OAM  = 2'd1;
  localparam logic [1:0] SRC_PAT  = 2'd2;
  localparam logic [1:0] SRC_NT   = 2'd3;

  localparam logic [13:0] NT_BASE = 14'h2000;
  localparam logic [13:0] NT_LAST = 14'h3EFF;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [2:0] flag_bits;
  } vrp_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] vram_addr;
    logic [14:0] temp_addr;
    logic [2:0]  fine_scroll_x;
    logic [7:0]  ctrl_value;
    logic [7:0]  mask_value;
  } vrp_out_t;

  function automatic logic [NT_AW-1:0] nt_index(logic [1:0] mode, logic [13:0] a);
    logic [13:0] idx;
    case (mode)
      MIR_VERT: idx = {3'b000, a[10:0]};
      MIR_HORZ: idx = {3'b000, a[11], a[9:0]};
      default:  idx = a - NT_BASE;
    endcase
    return idx[NT_AW-1:0];
  endfunction

  // backdrop entries 0x10/0x14/0x18/0x1c fold onto 0x00/0x04/0x08/0x0c
  function automatic logic [PAL_AW-1:0] pal_index(logic [13:0] a);
    logic [PAL_AW-1:0] idx;
    idx = a[PAL_AW-1:0];
    if (a[4] && a[1:0] == 2'b00) begin
      idx[4] = 1'b0;
    end
    return idx;
  endfunction

  function automatic logic [QP_W-1:0] q_next(logic [QP_W-1:0] p);
    return (p == QP_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/video_register_port_top.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------
// in       | request   | in_valid/in_stall  | in_data    (vrp_in_t)
// out      | result    | out_valid/out_stall| out_data   (vrp_out_t)
// cfg      | write     | cfg_write          | cfg_data   (mirror mode)
//
// one request per cycle while in_stall is low; a result passes the s1 register, which
// takes the registered read of oam, nametable or pattern ram, before it is queued
// after reset a clearing pass over PATTERN_BYTES (8192) addresses fills the rams, in_stall high
// a three-entry result queue absorbs out_stall; in_stall rises when queue plus the
// request in flight fill it
`default_nettype none
`include "video_register_port_top_macros.svh"

module video_register_port_top
  import vrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire vrp_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output vrp_out_t        out_data
);

  logic [1:0]  mirror_mode;
  logic [7:0]  control_byte, control_byte_next;
  logic [7:0]  mask_byte, mask_byte_next;
  logic [2:0]  status_flags, status_flags_next;
  logic [7:0]  sprite_addr, sprite_addr_next;
  logic [14:0] current_addr, current_addr_next;
  logic [14:0] temporary_addr, temporary_addr_next;
  logic [2:0]  fine_x, fine_x_next;
  logic        write_toggle, write_toggle_next;
  logic [7:0]  read_buffer, read_buffer_next;
  logic [7:0]  bus_byte, bus_byte_next;
  logic [7:0]  palette [PAL_BYTES];

  logic              clr_busy;
  logic [PAT_AW-1:0] clr_cnt;

  logic       s1_valid;
  logic [1:0] s1_src, src_next;
  vrp_out_t   s1_res, res_next, push_res;

  vrp_out_t        queue [QDEPTH];
  logic [QP_W-1:0] wr_ptr, rd_ptr;
  logic [QC_W-1:0] q_count;
  logic [QC_W:0]   occupancy;

  logic        in_acc, out_acc;
  logic [13:0] mem_addr;
  logic        addr_is_pat, addr_is_pal;
  logic [14:0] addr_inc;
  logic [7:0]  pal_rd;
  logic        pal_we;
  logic [14:0] t;
  logic [7:0]  bus_eff, buffer_eff;

  logic              pat_we, nt_we, oam_we;
  logic [PAT_AW-1:0] pat_addr;
  logic [NT_AW-1:0]  nt_addr;
  logic [OAM_AW-1:0] oam_addr;
  logic [7:0]        pat_wdata, nt_wdata, oam_wdata;
  logic [7:0]        pat_dout, nt_dout, oam_dout;

  assign occupancy = {1'b0, q_count} + {{QC_W{1'b0}}, s1_valid};
  assign in_stall  = clr_busy || (occupancy >= (QC_W+1)'(QDEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (q_count != '0);
  assign out_data  = queue[rd_ptr];
  assign out_acc   = out_valid && !out_stall;

  assign mem_addr    = current_addr[13:0];
  assign addr_is_pat = !mem_addr[13];
  assign addr_is_pal = mem_addr > NT_LAST;
  assign addr_inc    = current_addr + (control_byte[2] ? 15'd32 : 15'd1);
  assign pal_rd      = palette[pal_index(mem_addr)] & (mask_byte[0] ? 8'h30 : 8'hFF);

  // bytes still arriving from the ram read of the request in flight
  assign bus_eff    = (s1_valid && s1_src == SRC_OAM) ? oam_dout : bus_byte;
  assign buffer_eff = (s1_valid && s1_src == SRC_NT)  ? nt_dout :
                      (s1_valid && s1_src == SRC_PAT) ? pat_dout : read_buffer;

  always_comb begin
    push_res = s1_res;
    if (s1_src == SRC_OAM) begin
      push_res.read_data = oam_dout;
    end
  end

  always_comb begin
    control_byte_next   = control_byte;
    mask_byte_next      = mask_byte;
    status_flags_next   = status_flags;
    sprite_addr_next    = sprite_addr;
    current_addr_next   = current_addr;
    fine_x_next         = fine_x;
    write_toggle_next   = write_toggle;
    read_buffer_next    = buffer_eff;
    bus_byte_next       = bus_eff;
    t                   = temporary_addr;
    src_next            = SRC_NONE;
    pal_we              = 1'b0;
    pat_we              = 1'b0;
    nt_we               = 1'b0;
    oam_we              = 1'b0;
    if (in_acc) begin
      case (in_data.action)
        ACT_WRITE: begin
          bus_byte_next = in_data.write_data;
          case (in_data.reg_index)
            REG_CTRL: begin
              control_byte_next = in_data.write_data;
              t[11:10] = in_data.write_data[1:0];
            end
            REG_MASK: mask_byte_next = in_data.write_data;
            REG_OAM_ADDR: sprite_addr_next = in_data.write_data;
            REG_OAM_DATA: begin
              oam_we = 1'b1;
              sprite_addr_next = sprite_addr + 8'd1;
            end
            REG_SCROLL: begin
              if (!write_toggle) begin
                fine_x_next = in_data.write_data[2:0];
                t[4:0] = in_data.write_data[7:3];
              end else begin
                t[14:12] = in_data.write_data[2:0];
                t[9:5] = in_data.write_data[7:3];
              end
              write_toggle_next = !write_toggle;
            end
            REG_ADDR: begin
              if (!write_toggle) begin
                t[14:8] = {1'b0, in_data.write_data[5:0]};
              end else begin
                t[7:0] = in_data.write_data;
                current_addr_next = t;
              end
              write_toggle_next = !write_toggle;
            end
            REG_DATA: begin
              if (addr_is_pat) begin
                pat_we = 1'b1;
              end else if (addr_is_pal) begin
                pal_we = 1'b1;
              end else begin
                nt_we = 1'b1;
              end
              current_addr_next = addr_inc;
            end
            default: ;
          endcase
        end
        ACT_READ: begin
          case (in_data.reg_index)
            REG_STATUS: begin
              bus_byte_next = {status_flags, bus_eff[4:0]};
              status_flags_next = {1'b0, status_flags[1:0]};
              write_toggle_next = 1'b0;
            end
            REG_OAM_DATA: src_next = SRC_OAM;
            REG_DATA: begin
              if (addr_is_pal) begin
                read_buffer_next = pal_rd;
                bus_byte_next = pal_rd;
              end else begin
                bus_byte_next = buffer_eff;
                src_next = addr_is_pat ? SRC_PAT : SRC_NT;
              end
              current_addr_next = addr_inc;
            end
            default: ;
          endcase
        end
        ACT_SET: status_flags_next = status_flags | in_data.flag_bits;
        default: status_flags_next = status_flags & ~in_data.flag_bits;
      endcase
    end
    temporary_addr_next = t;
    res_next.read_data     = bus_byte_next;
    res_next.vram_addr     = current_addr_next;
    res_next.temp_addr     = temporary_addr_next;
    res_next.fine_scroll_x = fine_x_next;
    res_next.ctrl_value    = control_byte_next;
    res_next.mask_value    = mask_byte_next;
  end

  // ram ports: the clearing pass owns them after reset
  always_comb begin
    if (clr_busy) begin
      pat_addr  = clr_cnt;
      nt_addr   = clr_cnt[NT_AW-1:0];
      oam_addr  = clr_cnt[OAM_AW-1:0];
      pat_wdata = 8'h00;
      nt_wdata  = 8'hFF;
      oam_wdata = 8'h00;
    end else begin
      pat_addr  = mem_addr[PAT_AW-1:0];
      nt_addr   = nt_index(mirror_mode, mem_addr);
      oam_addr  = sprite_addr;
      pat_wdata = in_data.write_data;
      nt_wdata  = in_data.write_data;
      oam_wdata = in_data.write_data;
    end
  end

  vrp_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we || clr_busy),
    .addr  (pat_addr),
    .wdata (pat_wdata),
    .rdata (pat_dout)
  );

  vrp_ram #(.WIDTH(8), .DEPTH(NT_BYTES)) u_nt_ram (
    .clk   (clk),
    .we    (nt_we || clr_busy),
    .addr  (nt_addr),
    .wdata (nt_wdata),
    .rdata (nt_dout)
  );

  vrp_ram #(.WIDTH(8), .DEPTH(OAM_BYTES)) u_oam_ram (
    .clk   (clk),
    .we    (oam_we || clr_busy),
    .addr  (oam_addr),
    .wdata (oam_wdata),
    .rdata (oam_dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode    <= MIR_VERT;
      control_byte   <= '0;
      mask_byte      <= '0;
      status_flags   <= '0;
      sprite_addr    <= '0;
      current_addr   <= '0;
      temporary_addr <= '0;
      fine_x         <= '0;
      write_toggle   <= 1'b0;
      read_buffer    <= '0;
      bus_byte       <= '0;
      for (int i = 0; i < PAL_BYTES; i++) begin
        palette[i] <= '0;
      end
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
      s1_valid <= 1'b0;
      s1_src   <= SRC_NONE;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      q_count  <= '0;
    end else begin
      if (cfg_write) begin
        mirror_mode <= cfg_data;
      end
      control_byte   <= control_byte_next;
      mask_byte      <= mask_byte_next;
      status_flags   <= status_flags_next;
      sprite_addr    <= sprite_addr_next;
      current_addr   <= current_addr_next;
      temporary_addr <= temporary_addr_next;
      fine_x         <= fine_x_next;
      write_toggle   <= write_toggle_next;
      read_buffer    <= read_buffer_next;
      bus_byte       <= bus_byte_next;
      if (pal_we) begin
        palette[pal_index(mem_addr)] <= in_data.write_data;
      end
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == PAT_AW'(PATTERN_BYTES - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      s1_valid <= in_acc;
      s1_src   <= src_next;
      if (s1_valid) begin
        wr_ptr <= q_next(wr_ptr);
      end
      if (out_acc) begin
        rd_ptr <= q_next(rd_ptr);
      end
      q_count <= q_count + QC_W'(s1_valid) - QC_W'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    s1_res <= res_next;
    if (s1_valid) begin
      queue[wr_ptr] <= push_res;
    end
  end

  `VRP_ASSERT_NOW(a_queue_room, 1'b1, occupancy <= (QC_W+1)'(QDEPTH), "result queue overrun")
  `VRP_ASSERT_NEXT(a_in_flight, in_acc, s1_valid, "accepted request lost before its ram read")
  `VRP_ASSERT_NEXT(a_status_toggle, in_acc && in_data.action == ACT_READ && in_data.reg_index == REG_STATUS, !write_toggle && !status_flags[2], "status read left toggle or vblank set")
  `VRP_ASSERT_NOW(a_no_clear_accept, clr_busy, !in_acc && !s1_valid, "request taken during ram clearing")

endmodule

`default_nettype wire

>>> rtl/vrp_ram.sv
`default_nettype none

module vrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire
